### hdl/noa_pkg.sv
// Shared types, constants and helpers for the nearest object association unit.
package noa_pkg;

    localparam int MAX_OBJECTS_DEF = 16;
    localparam int COUNT_W         = 5;
    localparam int SLOT_W          = 4;
    localparam int POS_W           = 12;
    localparam int ABS_W           = 12;
    localparam int SQ_W            = 24;
    localparam int DIST_W          = 25;
    localparam int APB_ADDR_W      = 3;
    localparam int APB_DATA_W      = 32;

    localparam logic REG_OBJECT_COUNT = 1'b0;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef struct packed {
        op_t                       operation;
        logic [SLOT_W-1:0]         slot;
        logic signed [POS_W-1:0]   pos_x;
        logic signed [POS_W-1:0]   pos_y;
    } cmd_t;

    typedef struct packed {
        logic                      found;
        logic [SLOT_W-1:0]         nearest_slot;
        logic [DIST_W-1:0]         distance_squared;
    } result_t;

    typedef struct packed {
        logic valid;
        logic last;
    } tag_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_WALK,
        SEQ_DRAIN
    } seq_state_t;

    function automatic int idx_width(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

### hdl/noa_table.sv
// Object position table: one write port, one registered read port.
module noa_table
    import noa_pkg::*;
#(
    parameter int MAX_OBJECTS = MAX_OBJECTS_DEF,
    localparam int IDX_W = idx_width(MAX_OBJECTS)
)
(
    input  logic                    clk,
    input  logic                    wr_en,
    input  logic [IDX_W-1:0]        wr_addr,
    input  logic signed [POS_W-1:0] wr_x,
    input  logic signed [POS_W-1:0] wr_y,
    input  logic [IDX_W-1:0]        rd_addr,
    output logic signed [POS_W-1:0] rd_x,
    output logic signed [POS_W-1:0] rd_y
);

    logic signed [POS_W-1:0] mem_x [MAX_OBJECTS];
    logic signed [POS_W-1:0] mem_y [MAX_OBJECTS];
    logic signed [POS_W-1:0] rd_x_reg;
    logic signed [POS_W-1:0] rd_y_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_x[wr_addr] <= wr_x;
            mem_y[wr_addr] <= wr_y;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_x_reg <= mem_x[rd_addr];
        rd_y_reg <= mem_y[rd_addr];
    end

    assign rd_x = rd_x_reg;
    assign rd_y = rd_y_reg;

endmodule

### hdl/noa_dist.sv
// Pipelined squared-distance unit shared by every slot of a query.
module noa_dist
    import noa_pkg::*;
#(
    parameter int MAX_OBJECTS = MAX_OBJECTS_DEF,
    localparam int IDX_W = idx_width(MAX_OBJECTS)
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  tag_t                    issue,
    input  logic [IDX_W-1:0]        issue_idx,
    input  logic signed [POS_W-1:0] query_x,
    input  logic signed [POS_W-1:0] query_y,
    input  logic signed [POS_W-1:0] obj_x,
    input  logic signed [POS_W-1:0] obj_y,
    output tag_t                    out_tag,
    output logic [IDX_W-1:0]        out_idx,
    output logic [DIST_W-1:0]       out_dist
);

    tag_t             tag0_reg, tag1_reg, tag2_reg, tag3_reg;
    logic [IDX_W-1:0] idx0_reg, idx1_reg, idx2_reg, idx3_reg;
    logic [ABS_W-1:0] ax_reg, ay_reg;
    logic [ABS_W-1:0] ax_next, ay_next;
    logic [SQ_W-1:0]  sqx_reg, sqy_reg;
    logic [DIST_W-1:0] dist_reg;

    function automatic logic [ABS_W-1:0] abs_diff(
        input logic signed [POS_W-1:0] a,
        input logic signed [POS_W-1:0] b
    );
        logic signed [POS_W:0] d;
        d = {a[POS_W-1], a} - {b[POS_W-1], b};
        return d[POS_W] ? ABS_W'(-d) : ABS_W'(d);
    endfunction

    always_comb
    begin
        ax_next = abs_diff(query_x, obj_x);
        ay_next = abs_diff(query_y, obj_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag0_reg <= '0;
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
        end
        else
        begin
            tag0_reg <= issue;
            tag1_reg <= tag0_reg;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        idx0_reg <= issue_idx;
        idx1_reg <= idx0_reg;
        idx2_reg <= idx1_reg;
        idx3_reg <= idx2_reg;
        ax_reg   <= ax_next;
        ay_reg   <= ay_next;
        sqx_reg  <= SQ_W'(ax_reg) * SQ_W'(ax_reg);
        sqy_reg  <= SQ_W'(ay_reg) * SQ_W'(ay_reg);
        dist_reg <= DIST_W'(sqx_reg) + DIST_W'(sqy_reg);
    end

    assign out_tag  = tag3_reg;
    assign out_idx  = idx3_reg;
    assign out_dist = dist_reg;

endmodule

### hdl/noa_seq.sv
// Query sequencer: slot walk, running minimum and result strobe.
module noa_seq
    import noa_pkg::*;
#(
    parameter int MAX_OBJECTS = MAX_OBJECTS_DEF,
    localparam int IDX_W = idx_width(MAX_OBJECTS)
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  cmd_t                    cmd,
    input  logic [COUNT_W-1:0]      object_count,
    output logic                    busy,
    output logic                    wr_en,
    output logic [IDX_W-1:0]        wr_addr,
    output tag_t                    issue,
    output logic [IDX_W-1:0]        issue_idx,
    output logic signed [POS_W-1:0] query_x,
    output logic signed [POS_W-1:0] query_y,
    input  tag_t                    d_tag,
    input  logic [IDX_W-1:0]        d_idx,
    input  logic [DIST_W-1:0]       d_dist,
    output logic                    result_valid,
    output result_t                 result
);

    seq_state_t              state_reg, state_next;
    logic [COUNT_W-1:0]      cnt_reg;
    logic [COUNT_W-1:0]      limit_reg;
    logic [COUNT_W-1:0]      limit_now;
    logic signed [POS_W-1:0] qx_reg, qy_reg;
    logic [DIST_W-1:0]       best_d_reg;
    logic [IDX_W-1:0]        best_slot_reg;
    logic                    result_valid_reg;
    result_t                 result_reg;
    logic                    accept;
    logic                    query_go;
    logic                    empty_go;
    logic                    take;
    logic [DIST_W-1:0]       new_d;
    logic [IDX_W-1:0]        new_slot;

    always_comb
    begin
        limit_now = (int'(object_count) > MAX_OBJECTS) ? COUNT_W'(MAX_OBJECTS)
                                                       : object_count;
        accept    = start && (state_reg == SEQ_IDLE);
        query_go  = accept && (cmd.operation == OP_QUERY);
        empty_go  = query_go && (limit_now == '0);
        take      = (d_idx == '0) || (d_dist < best_d_reg);
        new_d     = take ? d_dist : best_d_reg;
        new_slot  = take ? d_idx : best_slot_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SEQ_IDLE:
            begin
                if (query_go && !empty_go)
                    state_next = SEQ_WALK;
            end
            SEQ_WALK:
            begin
                if (cnt_reg == limit_reg - 1'b1)
                    state_next = SEQ_DRAIN;
            end
            SEQ_DRAIN:
            begin
                if (d_tag.valid && d_tag.last)
                    state_next = SEQ_IDLE;
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy       = (state_reg != SEQ_IDLE);
        wr_en      = accept && (cmd.operation == OP_LOAD) && (int'(cmd.slot) < MAX_OBJECTS);
        wr_addr    = IDX_W'(cmd.slot);
        issue.valid = (state_reg == SEQ_WALK);
        issue.last  = (state_reg == SEQ_WALK) && (cnt_reg == limit_reg - 1'b1);
        issue_idx  = IDX_W'(cnt_reg);
        query_x    = qx_reg;
        query_y    = qy_reg;
        result_valid = result_valid_reg;
        result     = result_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= SEQ_IDLE;
            cnt_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= (d_tag.valid && d_tag.last) || empty_go;
            if (query_go)
                cnt_reg <= '0;
            else if (state_reg == SEQ_WALK)
                cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (query_go)
        begin
            limit_reg <= limit_now;
            qx_reg    <= cmd.pos_x;
            qy_reg    <= cmd.pos_y;
        end
        if (d_tag.valid)
        begin
            best_d_reg    <= new_d;
            best_slot_reg <= new_slot;
        end
        if (d_tag.valid && d_tag.last)
        begin
            result_reg.found            <= 1'b1;
            result_reg.nearest_slot     <= SLOT_W'(new_slot);
            result_reg.distance_squared <= new_d;
        end
        else if (empty_go)
        begin
            result_reg <= '0;
        end
    end

    a_drain_before_idle: assert property (@(posedge clk) disable iff (!rst_n)
        d_tag.valid |-> state_reg != SEQ_IDLE)
        else $error("distance pipeline active while sequencer idle");

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        d_tag.valid && d_tag.last |=> result_valid && result.found)
        else $error("last slot compared but no found result");

    a_found_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.found |-> $past(d_tag.valid && d_tag.last))
        else $error("found result without a completed walk");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == SEQ_WALK |=> state_reg != SEQ_IDLE)
        else $error("walk returned to idle without draining");

endmodule

### hdl/nearest_object_association_unit.sv
// Top level of the nearest object association unit with its APB register.
// A load word (start with busy low) writes one table slot and returns no
// result. A query word walks slots 0 .. min(object_count, MAX_OBJECTS)-1
// through one pipelined distance-and-compare unit, one slot per cycle, and
// holds busy until the last slot has passed the table read, difference,
// square and sum registers and been compared.
// The result strobe rises for one cycle as busy falls, and the receiver
// cannot stall it. An empty table gives found = 0 in the cycle after the
// query without raising busy.
module nearest_object_association_unit
    import noa_pkg::*;
#(
    parameter int MAX_OBJECTS = MAX_OBJECTS_DEF,
    localparam int IDX_W = idx_width(MAX_OBJECTS)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  cmd_t                  cmd,
    output logic                  busy,
    output logic                  result_valid,
    output result_t               result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [COUNT_W-1:0]      count_reg;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    tag_t                    issue;
    logic [IDX_W-1:0]        issue_idx;
    logic signed [POS_W-1:0] query_x, query_y;
    logic signed [POS_W-1:0] obj_x, obj_y;
    tag_t                    d_tag;
    logic [IDX_W-1:0]        d_idx;
    logic [DIST_W-1:0]       d_dist;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (psel && penable && pwrite && (paddr[2] == REG_OBJECT_COUNT))
            count_reg <= pwdata[COUNT_W-1:0];
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_OBJECT_COUNT)
            prdata = APB_DATA_W'(count_reg);
    end

    noa_seq #(.MAX_OBJECTS(MAX_OBJECTS)) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .cmd          (cmd),
        .object_count (count_reg),
        .busy         (busy),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .issue        (issue),
        .issue_idx    (issue_idx),
        .query_x      (query_x),
        .query_y      (query_y),
        .d_tag        (d_tag),
        .d_idx        (d_idx),
        .d_dist       (d_dist),
        .result_valid (result_valid),
        .result       (result)
    );

    noa_table #(.MAX_OBJECTS(MAX_OBJECTS)) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_x    (cmd.pos_x),
        .wr_y    (cmd.pos_y),
        .rd_addr (issue_idx),
        .rd_x    (obj_x),
        .rd_y    (obj_y)
    );

    noa_dist #(.MAX_OBJECTS(MAX_OBJECTS)) u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue     (issue),
        .issue_idx (issue_idx),
        .query_x   (query_x),
        .query_y   (query_y),
        .obj_x     (obj_x),
        .obj_y     (obj_y),
        .out_tag   (d_tag),
        .out_idx   (d_idx),
        .out_dist  (d_dist)
    );

endmodule
